### sv/llre_pkg.sv
// ----------------------------------------------------------------------------
// llre_pkg
// Shared types and constants of the linked list reorder engine.
// ----------------------------------------------------------------------------
package llre_pkg;

	localparam int MAX_ITEMS_DEFAULT = 1024;
	localparam int CMD_W             = 3;
	localparam int ITEM_W            = 11;
	localparam int SUM_W             = 20;
	localparam int JOIN_SLOTS        = 4;
	localparam logic [ITEM_W-1:0] ITEM_COUNT_RESET = ITEM_W'(1024);

	typedef enum logic [CMD_W-1:0] {
		CMD_INIT    = 3'd0,
		CMD_LEFT    = 3'd1,
		CMD_RIGHT   = 3'd2,
		CMD_SWAP    = 3'd3,
		CMD_REVERSE = 3'd4,
		CMD_SUM     = 3'd5
	} cmd_t;

endpackage

### sv/linked_list_reorder_engine.sv
// ----------------------------------------------------------------------------
// linked_list_reorder_engine
// Doubly linked list of items 1..n in two link memories, with lazy reversal.
// ----------------------------------------------------------------------------
// Items are kept in a circular list through a head node, with the previous and
// next links each in a memory of MAX_ITEMS+1 entries. One transaction is worked
// at a time. Reverse only toggles a flag. A move or swap reads the links of x,
// then those of y, builds its relink plan in a decision state and then writes
// the relinked pairs in turn; an ignored move or swap writes no links. Init
// writes one link pair per cycle, then closes the ring at the head. Sum walks the
// list by the link read out of the next memory in the previous cycle; its result
// waits in an output register, so further commands are taken while it is pending.
// Any move, swap or sum must come after the first init.
module linked_list_reorder_engine #(
	parameter int MAX_ITEMS = llre_pkg::MAX_ITEMS_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [llre_pkg::ITEM_W-1:0] cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [llre_pkg::CMD_W-1:0]  command,
	input  logic [llre_pkg::ITEM_W-1:0] item_x,
	input  logic [llre_pkg::ITEM_W-1:0] item_y,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [llre_pkg::SUM_W-1:0]  odd_position_sum
);

	import llre_pkg::*;

	localparam int DEPTH = MAX_ITEMS + 1;
	localparam int LW    = $clog2(DEPTH);
	localparam int PW    = (2 * LW + 1 > SUM_W + 1) ? 2 * LW + 1 : SUM_W + 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RDY,
		S_DEC,
		S_JOIN,
		S_INIT,
		S_INIT_END,
		S_WALK,
		S_FINISH
	} state_t;

	state_t          state_q;
	logic [ITEM_W-1:0] item_count_q;
	logic            reversed_q;
	cmd_t            cmd_q;
	logic [LW-1:0]   x_q, y_q, xl_q, xr_q;
	logic [LW-1:0]   walk_i_q;
	logic [SUM_W-1:0] acc_q;
	logic [PW-1:0]   prod_q;
	logic            out_valid_q;
	logic [SUM_W-1:0] out_sum_q;
	logic [LW-1:0]   ja_q [JOIN_SLOTS];
	logic [LW-1:0]   jb_q [JOIN_SLOTS];
	logic [2:0]      jcnt_q;
	logic [1:0]      jidx_q;

	logic [LW-1:0]   n_eff;
	logic            accept, ops_ok;
	cmd_t            in_cmd;

	logic            prev_we, next_we;
	logic [LW-1:0]   prev_waddr, next_waddr, prev_wdata, next_wdata;
	logic [LW-1:0]   prev_raddr, next_raddr, prev_rd, next_rd;

	logic [LW-1:0]   j_a [JOIN_SLOTS];
	logic [LW-1:0]   j_b [JOIN_SLOTS];
	logic [2:0]      j_cnt;
	logic [LW-1:0]   sx, sy, sxl, sxr, syl, syr;
	logic            move_left;

	assign in_cmd   = cmd_t'(command);
	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_valid        = out_valid_q;
	assign odd_position_sum = out_sum_q;

	// Effective item count, saturated to 1..MAX_ITEMS.
	always_comb begin
		if (item_count_q == '0) begin
			n_eff = LW'(1);
		end else if (32'(item_count_q) > 32'(MAX_ITEMS)) begin
			n_eff = LW'(MAX_ITEMS);
		end else begin
			n_eff = LW'(item_count_q);
		end
	end

	assign ops_ok = (item_x != '0) && (32'(item_x) <= 32'(n_eff)) &&
		(item_y != '0) && (32'(item_y) <= 32'(n_eff)) && (item_x != item_y);

	// Read addresses. The walk follows the link that just came out of memory.
	always_comb begin
		prev_raddr = x_q;
		next_raddr = x_q;
		unique case (state_q)
			S_IDLE: begin
				prev_raddr = LW'(item_x);
				next_raddr = (in_cmd == CMD_SUM) ? '0 : LW'(item_x);
			end
			S_RDY: begin
				prev_raddr = y_q;
				next_raddr = y_q;
			end
			S_WALK: next_raddr = next_rd;
			default: ;
		endcase
	end

	// Write ports: each relinked pair a->b writes next[a] = b and prev[b] = a.
	always_comb begin
		prev_we    = 1'b0;
		next_we    = 1'b0;
		next_waddr = ja_q[jidx_q];
		next_wdata = jb_q[jidx_q];
		prev_waddr = jb_q[jidx_q];
		prev_wdata = ja_q[jidx_q];
		unique case (state_q)
			S_JOIN: begin
				prev_we = 1'b1;
				next_we = 1'b1;
			end
			S_INIT: begin
				prev_we    = 1'b1;
				next_we    = 1'b1;
				next_waddr = walk_i_q - LW'(1);
				next_wdata = walk_i_q;
				prev_waddr = walk_i_q;
				prev_wdata = walk_i_q - LW'(1);
			end
			S_INIT_END: begin
				prev_we    = 1'b1;
				next_we    = 1'b1;
				next_waddr = n_eff;
				next_wdata = '0;
				prev_waddr = '0;
				prev_wdata = n_eff;
			end
			default: ;
		endcase
	end

	// Relink plan, built when the links of y come out of memory.
	always_comb begin
		j_a   = '{default: '0};
		j_b   = '{default: '0};
		j_cnt = 3'd0;
		move_left = (cmd_q == CMD_LEFT) ^ reversed_q;
		// When y sits directly left of x, the swap is done with the roles exchanged.
		if (next_rd == x_q) begin
			sx = y_q;  sy = x_q;
			sxl = prev_rd; sxr = next_rd;
			syl = xl_q;    syr = xr_q;
		end else begin
			sx = x_q;  sy = y_q;
			sxl = xl_q;    sxr = xr_q;
			syl = prev_rd; syr = next_rd;
		end
		if (cmd_q == CMD_SWAP) begin
			if (sxr == sy) begin
				j_a[0] = sxl; j_b[0] = sy;
				j_a[1] = sy;  j_b[1] = sx;
				j_a[2] = sx;  j_b[2] = syr;
				j_cnt  = 3'd3;
			end else begin
				j_a[0] = sxl; j_b[0] = sy;
				j_a[1] = sy;  j_b[1] = sxr;
				j_a[2] = syl; j_b[2] = sx;
				j_a[3] = sx;  j_b[3] = syr;
				j_cnt  = 3'd4;
			end
		end else if (move_left) begin
			if (prev_rd != x_q) begin
				j_a[0] = xl_q;    j_b[0] = xr_q;
				j_a[1] = prev_rd; j_b[1] = x_q;
				j_a[2] = x_q;     j_b[2] = y_q;
				j_cnt  = 3'd3;
			end
		end else begin
			if (next_rd != x_q) begin
				j_a[0] = xl_q; j_b[0] = xr_q;
				j_a[1] = x_q;  j_b[1] = next_rd;
				j_a[2] = y_q;  j_b[2] = x_q;
				j_cnt  = 3'd3;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			item_count_q <= ITEM_COUNT_RESET;
			reversed_q   <= 1'b0;
			cmd_q        <= CMD_INIT;
			x_q          <= '0;
			y_q          <= '0;
			xl_q         <= '0;
			xr_q         <= '0;
			walk_i_q     <= '0;
			acc_q        <= '0;
			prod_q       <= '0;
			out_valid_q  <= 1'b0;
			out_sum_q    <= '0;
			ja_q         <= '{default: '0};
			jb_q         <= '{default: '0};
			jcnt_q       <= '0;
			jidx_q       <= '0;
		end else begin
			if (cfg_wr_en) begin
				item_count_q <= cfg_wr_data;
			end
			if (out_valid_q && out_ready && state_q != S_FINISH) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (in_cmd)
							CMD_INIT: begin
								reversed_q <= 1'b0;
								walk_i_q   <= LW'(1);
								state_q    <= S_INIT;
							end
							CMD_REVERSE: reversed_q <= !reversed_q;
							CMD_SUM: begin
								walk_i_q <= LW'(1);
								acc_q    <= '0;
								prod_q   <= PW'(n_eff) * (PW'(n_eff) + PW'(1));
								state_q  <= S_WALK;
							end
							CMD_LEFT, CMD_RIGHT, CMD_SWAP: begin
								if (ops_ok) begin
									cmd_q   <= in_cmd;
									x_q     <= LW'(item_x);
									y_q     <= LW'(item_y);
									state_q <= S_RDY;
								end
							end
							default: ;
						endcase
					end
				end
				S_RDY: begin
					xl_q    <= prev_rd;
					xr_q    <= next_rd;
					state_q <= S_DEC;
				end
				S_DEC: begin
					ja_q    <= j_a;
					jb_q    <= j_b;
					jcnt_q  <= j_cnt;
					jidx_q  <= '0;
					state_q <= (j_cnt == 3'd0) ? S_IDLE : S_JOIN;
				end
				S_JOIN: begin
					jidx_q <= jidx_q + 2'd1;
					if (3'(jidx_q) + 3'd1 == jcnt_q) begin
						state_q <= S_IDLE;
					end
				end
				S_INIT: begin
					walk_i_q <= walk_i_q + LW'(1);
					if (walk_i_q == n_eff) begin
						state_q <= S_INIT_END;
					end
				end
				S_INIT_END: state_q <= S_IDLE;
				S_WALK: begin
					if (walk_i_q[0]) begin
						acc_q <= acc_q + SUM_W'(next_rd);
					end
					walk_i_q <= walk_i_q + LW'(1);
					if (walk_i_q == n_eff) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (!out_valid_q || out_ready) begin
						// Reversed with even n: report the complement of the sum.
						out_sum_q   <= (reversed_q && !n_eff[0]) ?
							prod_q[SUM_W:1] - acc_q : acc_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	llre_link_ram #(
		.DEPTH(DEPTH),
		.WIDTH(LW)
	) u_prev_ram (
		.clk  (clk),
		.we   (prev_we),
		.waddr(prev_waddr),
		.wdata(prev_wdata),
		.raddr(prev_raddr),
		.rdata(prev_rd)
	);

	llre_link_ram #(
		.DEPTH(DEPTH),
		.WIDTH(LW)
	) u_next_ram (
		.clk  (clk),
		.we   (next_we),
		.waddr(next_waddr),
		.wdata(next_wdata),
		.raddr(next_raddr),
		.rdata(next_rd)
	);

`ifndef ASSERT_OFF
	a_join_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_JOIN) |-> (3'(jidx_q) < jcnt_q))
		else $error("relink index beyond plan");

	a_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> ((walk_i_q != '0) && (walk_i_q <= n_eff)))
		else $error("walk counter out of range");

	a_no_write_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RDY || state_q == S_DEC || state_q == S_WALK) |->
		(!prev_we && !next_we))
		else $error("link write while links are being read");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q != S_FINISH) && !out_valid_q) |=> !out_valid_q)
		else $error("result raised outside the sum finish");
`endif

endmodule

### sv/llre_link_ram.sv
// ----------------------------------------------------------------------------
// llre_link_ram
// Link memory: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module llre_link_ram #(
	parameter int DEPTH = 1025,
	parameter int WIDTH = 11
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
